// ----- design/gbm_pkg.sv -----
package gbm_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_CLIP,
      ST_MUL_K,
      ST_KSET,
      ST_MUL_R,
      ST_RSET,
      ST_CORR,
      ST_EXP,
      ST_MUL_M,
      ST_MSAT,
      ST_MUL_T,
      ST_SHIFT
   } state_type;

   typedef enum logic [1:0] {
      REG_INITIAL_PRICE = 2'd0,
      REG_DRIFT_FACTOR  = 2'd1,
      REG_STEP_VOL      = 2'd2,
      REG_PATH_STEPS    = 2'd3
   } reg_index_type;

   localparam logic [30:0] INITIAL_PRICE_RESET = 31'd3276800;
   localparam logic [31:0] DRIFT_FACTOR_RESET  = 32'd65536;
   localparam logic [30:0] STEP_VOL_RESET      = 31'd0;
   localparam logic [15:0] PATH_STEPS_RESET    = 16'd10;

   localparam logic [31:0] EXP_ONE    = 32'd1073741824;
   localparam logic [16:0] LN2        = 17'd45426;
   localparam logic [16:0] INV_LN2    = 17'd94548;
   localparam logic [22:0] ARG_LIMIT  = 23'd4194304;
   localparam logic [31:0] PRICE_MAX  = 32'hFFFF_FFFF;
   localparam logic [2:0]  CORR_STEPS = 3'd4;
   localparam logic [4:0]  EXP_STEPS  = 5'd16;
   localparam logic [8:0]  EXP_BIAS   = 9'd30;

   // ln(1 + 2^-i) in Q16.16
   function automatic logic [16:0] ln_term(input logic [4:0] idx);
      logic [16:0] v;
      unique case (idx)
         5'd1:    v = 17'd26573;
         5'd2:    v = 17'd14624;
         5'd3:    v = 17'd7719;
         5'd4:    v = 17'd3973;
         5'd5:    v = 17'd2017;
         5'd6:    v = 17'd1016;
         5'd7:    v = 17'd510;
         5'd8:    v = 17'd256;
         5'd9:    v = 17'd128;
         5'd10:   v = 17'd64;
         5'd11:   v = 17'd32;
         5'd12:   v = 17'd16;
         5'd13:   v = 17'd8;
         5'd14:   v = 17'd4;
         5'd15:   v = 17'd2;
         5'd16:   v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/gbm_path_step_core.sv -----
// GBM path step core: advances a lognormal price path by one step per beat.
// Input channel req_*: one signed Q16.16 standard-normal sample per beat,
// taken when req_valid is high and req_stall is low.
// Result channel rsp_*: one beat per input beat carrying the new unsigned
// Q16.16 price (saturating) and a flag on the final step of each path.
// Config via APB (psel/penable/...): initial_price @0x0, drift_factor @0x4,
// step_vol @0x8, path_steps @0xC; write only while the core is idle.
// The core works on one sample at a time: a new sample is taken only
// after the previous item has finished its last step. All products run
// through a single shared 33x33 multiplier, and exp() is a 16-step
// shift-and-add loop preceded by 4 range-correction steps.
// req_stall is high while an item is in progress. A finished result sits in
// the output register, so the next sample can be taken while it waits; if
// the receiver still stalls when the following result is ready, the core
// holds in its last step until the output register frees.
// Reset (synchronous, active high) restores the register defaults, clears
// the path state and drops any pending result.
module gbm_path_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_normal_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_price,
   output logic               rsp_last_of_path,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   gbm_pkg::state_type state_ff, state_in;

   logic [30:0] initial_price_ff;
   logic [31:0] drift_factor_ff;
   logic [30:0] step_vol_ff;
   logic [15:0] path_steps_ff;

   logic [31:0] current_price_ff;
   logic [15:0] step_index_ff;

   logic signed [31:0] z_ff;
   logic [31:0]        prev_ff;
   logic               last_ff;
   logic signed [23:0] a_ff;
   logic signed [7:0]  k_ff;
   logic signed [24:0] r_ff;
   logic [31:0]        y_ff;
   logic [31:0]        m_ff;
   logic signed [65:0] prod_ff;
   logic [4:0]         cnt_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_price_ff;
   logic        rsp_last_ff;

   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;

   logic        req_take;
   logic        out_free;
   logic        cfg_write;
   logic [15:0] steps_eff;
   logic        last_calc;

   logic signed [49:0] a_full;
   logic signed [23:0] a_clip;
   logic [16:0]        term;
   logic               term_hit;
   logic [63:0]        total;
   logic signed [8:0]  sh;
   logic [7:0]         sh_neg;
   logic [95:0]        left_val;
   logic [63:0]        right_val;
   logic [31:0]        price_calc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   assign steps_eff = (path_steps_ff == 16'd0) ? 16'd1 : path_steps_ff;
   assign last_calc = ({1'b0, step_index_ff} + 17'd1) >= {1'b0, steps_eff};

   assign a_full = prod_ff[65:16];
   always_comb begin
      if (a_full > $signed({27'd0, gbm_pkg::ARG_LIMIT})) begin
         a_clip = $signed({1'b0, gbm_pkg::ARG_LIMIT});
      end else if (a_full < -$signed({27'd0, gbm_pkg::ARG_LIMIT})) begin
         a_clip = -$signed({1'b0, gbm_pkg::ARG_LIMIT});
      end else begin
         a_clip = a_full[23:0];
      end
   end

   assign term     = gbm_pkg::ln_term(cnt_ff);
   assign term_hit = r_ff >= $signed({8'd0, term});

   assign total     = prod_ff[63:0];
   assign sh        = {k_ff[7], k_ff} - $signed(gbm_pkg::EXP_BIAS);
   assign sh_neg    = 8'(-sh);
   assign left_val  = {32'd0, total} << sh[4:0];
   assign right_val = total >> sh_neg[5:0];

   always_comb begin
      if (!sh[8]) begin
         if (total == 64'd0) begin
            price_calc = 32'd0;
         end else if (sh >= 9'sd32) begin
            price_calc = gbm_pkg::PRICE_MAX;
         end else if (left_val[95:32] != 64'd0) begin
            price_calc = gbm_pkg::PRICE_MAX;
         end else begin
            price_calc = left_val[31:0];
         end
      end else begin
         if (sh_neg >= 8'd64) begin
            price_calc = 32'd0;
         end else if (right_val[63:32] != 32'd0) begin
            price_calc = gbm_pkg::PRICE_MAX;
         end else begin
            price_calc = right_val[31:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbm_pkg::ST_IDLE:  if (req_valid) state_in = gbm_pkg::ST_MUL_A;
         gbm_pkg::ST_MUL_A: state_in = gbm_pkg::ST_CLIP;
         gbm_pkg::ST_CLIP:  state_in = gbm_pkg::ST_MUL_K;
         gbm_pkg::ST_MUL_K: state_in = gbm_pkg::ST_KSET;
         gbm_pkg::ST_KSET:  state_in = gbm_pkg::ST_MUL_R;
         gbm_pkg::ST_MUL_R: state_in = gbm_pkg::ST_RSET;
         gbm_pkg::ST_RSET:  state_in = gbm_pkg::ST_CORR;
         gbm_pkg::ST_CORR: begin
            if (cnt_ff == 5'(gbm_pkg::CORR_STEPS - 3'd1)) state_in = gbm_pkg::ST_EXP;
         end
         gbm_pkg::ST_EXP: begin
            if (cnt_ff == gbm_pkg::EXP_STEPS) state_in = gbm_pkg::ST_MUL_M;
         end
         gbm_pkg::ST_MUL_M: state_in = gbm_pkg::ST_MSAT;
         gbm_pkg::ST_MSAT:  state_in = gbm_pkg::ST_MUL_T;
         gbm_pkg::ST_MUL_T: state_in = gbm_pkg::ST_SHIFT;
         gbm_pkg::ST_SHIFT: if (out_free) state_in = gbm_pkg::ST_IDLE;
         default:           state_in = gbm_pkg::ST_IDLE;
      endcase
   end

   // outputs and shared multiplier operands
   always_comb begin
      req_stall = (state_ff != gbm_pkg::ST_IDLE);
      mul_a     = 33'sd0;
      mul_b     = 33'sd0;
      unique case (state_ff)
         gbm_pkg::ST_MUL_A: begin
            mul_a = $signed({2'b00, step_vol_ff});
            mul_b = {z_ff[31], z_ff};
         end
         gbm_pkg::ST_MUL_K: begin
            mul_a = {{9{a_ff[23]}}, a_ff};
            mul_b = $signed({16'd0, gbm_pkg::INV_LN2});
         end
         gbm_pkg::ST_MUL_R: begin
            mul_a = {{25{k_ff[7]}}, k_ff};
            mul_b = $signed({16'd0, gbm_pkg::LN2});
         end
         gbm_pkg::ST_MUL_M: begin
            mul_a = $signed({1'b0, prev_ff});
            mul_b = $signed({1'b0, drift_factor_ff});
         end
         gbm_pkg::ST_MUL_T: begin
            mul_a = $signed({1'b0, m_ff});
            mul_b = $signed({1'b0, y_ff});
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= gbm_pkg::ST_IDLE;
         initial_price_ff <= gbm_pkg::INITIAL_PRICE_RESET;
         drift_factor_ff  <= gbm_pkg::DRIFT_FACTOR_RESET;
         step_vol_ff      <= gbm_pkg::STEP_VOL_RESET;
         path_steps_ff    <= gbm_pkg::PATH_STEPS_RESET;
         current_price_ff <= 32'd0;
         step_index_ff    <= 16'd0;
         rsp_valid_ff     <= 1'b0;
         cnt_ff           <= 5'd0;
      end else begin
         state_ff <= state_in;
         if (cfg_write) begin
            unique case (gbm_pkg::reg_index_type'(paddr[3:2]))
               gbm_pkg::REG_INITIAL_PRICE: initial_price_ff <= pwdata[30:0];
               gbm_pkg::REG_DRIFT_FACTOR:  drift_factor_ff  <= pwdata;
               gbm_pkg::REG_STEP_VOL:      step_vol_ff      <= pwdata[30:0];
               gbm_pkg::REG_PATH_STEPS:    path_steps_ff    <= pwdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == gbm_pkg::ST_SHIFT && out_free) begin
            rsp_valid_ff     <= 1'b1;
            current_price_ff <= price_calc;
            step_index_ff    <= last_ff ? 16'd0 : step_index_ff + 16'd1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            gbm_pkg::ST_RSET: cnt_ff <= 5'd0;
            gbm_pkg::ST_CORR: begin
               cnt_ff <= (cnt_ff == 5'(gbm_pkg::CORR_STEPS - 3'd1)) ? 5'd1 : cnt_ff + 5'd1;
            end
            gbm_pkg::ST_EXP:  cnt_ff <= cnt_ff + 5'd1;
            default:          cnt_ff <= cnt_ff;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      // product held while the last step waits on the output register
      if (state_ff != gbm_pkg::ST_SHIFT) begin
         prod_ff <= mul_a * mul_b;
      end
      if (req_take) begin
         z_ff    <= req_normal_sample;
         prev_ff <= (step_index_ff == 16'd0) ? {1'b0, initial_price_ff} : current_price_ff;
         last_ff <= last_calc;
      end
      unique case (state_ff)
         gbm_pkg::ST_CLIP: a_ff <= a_clip;
         gbm_pkg::ST_KSET: k_ff <= prod_ff[39:32];
         gbm_pkg::ST_RSET: begin
            r_ff <= {a_ff[23], a_ff} - prod_ff[24:0];
            y_ff <= gbm_pkg::EXP_ONE;
         end
         gbm_pkg::ST_CORR: begin
            if (r_ff < 25'sd0) begin
               r_ff <= r_ff + $signed({8'd0, gbm_pkg::LN2});
               k_ff <= k_ff - 8'sd1;
            end else if (r_ff >= $signed({8'd0, gbm_pkg::LN2})) begin
               r_ff <= r_ff - $signed({8'd0, gbm_pkg::LN2});
               k_ff <= k_ff + 8'sd1;
            end
         end
         gbm_pkg::ST_EXP: begin
            if (term_hit) begin
               r_ff <= r_ff - $signed({8'd0, term});
               y_ff <= y_ff + (y_ff >> cnt_ff);
            end
         end
         gbm_pkg::ST_MSAT: begin
            m_ff <= (prod_ff[63:48] != 16'd0) ? gbm_pkg::PRICE_MAX : prod_ff[47:16];
         end
         gbm_pkg::ST_SHIFT: begin
            if (out_free) begin
               rsp_price_ff <= price_calc;
               rsp_last_ff  <= last_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (gbm_pkg::reg_index_type'(paddr[3:2]))
         gbm_pkg::REG_INITIAL_PRICE: prdata = {1'b0, initial_price_ff};
         gbm_pkg::REG_DRIFT_FACTOR:  prdata = drift_factor_ff;
         gbm_pkg::REG_STEP_VOL:      prdata = {1'b0, step_vol_ff};
         gbm_pkg::REG_PATH_STEPS:    prdata = {16'd0, path_steps_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_price        = rsp_price_ff;
   assign rsp_last_of_path = rsp_last_ff;

endmodule
